// File: rtl/core/one_wire_bus_master_core_assert.svh
// Assertion macros for the single-wire bus master core.
// Labelled concurrent checks on clk, disabled while arst_n is low,
// and a variant that keeps checking through reset.
`ifndef ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define OWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OWM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWM_ASSERT(lbl, prop, msg)
`define OWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/owm_pkg.sv
package owm_pkg;

	localparam int CNT_W = 10;

	localparam logic [CNT_W-1:0] READ_LOW_TICKS  = 10'd2;
	localparam logic [CNT_W-1:0] READ_TAIL_TICKS = 10'd50;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_RESET = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] CFG_RESET_TAIL    = 3'd2;
	localparam logic [2:0] CFG_W1_LOW        = 3'd3;
	localparam logic [2:0] CFG_W1_RELEASE    = 3'd4;
	localparam logic [2:0] CFG_W0_LOW        = 3'd5;
	localparam logic [2:0] CFG_W0_RELEASE    = 3'd6;
	localparam logic [2:0] CFG_READ_SAMPLE   = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_BIT_LOW  = 3'd4,
		PH_BIT_WAIT = 3'd5,
		PH_BIT_TAIL = 3'd6
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] reset_low;
		logic [CNT_W-1:0] presence_wait;
		logic [CNT_W-1:0] reset_tail;
		logic [CNT_W-1:0] w1_low;
		logic [CNT_W-1:0] w1_release;
		logic [CNT_W-1:0] w0_low;
		logic [CNT_W-1:0] w0_release;
		logic [CNT_W-1:0] read_sample;
	} owm_cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] write_data;
		logic       line_level;
	} owm_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] slot_counter;
		logic [2:0]       bit_index;
		logic [7:0]       shift_byte;
		logic [1:0]       operation;
		logic             presence_flag;
		logic [7:0]       last_read;
	} owm_state_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
	} owm_res_t;

	// zero length segments last one tick
	function automatic logic [CNT_W-1:0] seg_len(input logic [CNT_W-1:0] v);
		return (v == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : v;
	endfunction

	function automatic logic [CNT_W-1:0] low_len(input logic [1:0] op, input logic bit0,
			input owm_cfg_t c);
		if (op == OP_READ)
			return READ_LOW_TICKS;
		return seg_len(bit0 ? c.w1_low : c.w0_low);
	endfunction

	function automatic logic [CNT_W-1:0] release_len(input logic [1:0] op, input logic bit0,
			input owm_cfg_t c);
		if (op == OP_READ)
			return seg_len(c.read_sample);
		return seg_len(bit0 ? c.w1_release : c.w0_release);
	endfunction

endpackage

// File: rtl/core/owm_cfg.sv
module owm_cfg
	import owm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output owm_cfg_t         cfg
);

	owm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= 10'd480;
			cfg_q.presence_wait <= 10'd70;
			cfg_q.reset_tail    <= 10'd410;
			cfg_q.w1_low        <= 10'd5;
			cfg_q.w1_release    <= 10'd55;
			cfg_q.w0_low        <= 10'd60;
			cfg_q.w0_release    <= 10'd5;
			cfg_q.read_sample   <= 10'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_data;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data;
				CFG_RESET_TAIL:    cfg_q.reset_tail    <= cfg_data;
				CFG_W1_LOW:        cfg_q.w1_low        <= cfg_data;
				CFG_W1_RELEASE:    cfg_q.w1_release    <= cfg_data;
				CFG_W0_LOW:        cfg_q.w0_low        <= cfg_data;
				CFG_W0_RELEASE:    cfg_q.w0_release    <= cfg_data;
				CFG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

endmodule

// File: rtl/core/owm_step.sv
module owm_step
	import owm_pkg::*;
(
	input  owm_cfg_t   cfg,
	input  owm_state_t cur,
	input  owm_item_t  item,
	output owm_state_t nxt,
	output owm_res_t   res
);

	function automatic owm_state_t end_bit(input owm_state_t s, input owm_cfg_t c);
		owm_state_t r;
		r = s;
		if (r.operation != OP_READ)
			r.shift_byte = r.shift_byte >> 1;
		r.bit_index = r.bit_index + 3'd1;
		if (r.bit_index == 3'd0) begin
			r.phase = PH_IDLE;
			if (r.operation == OP_READ)
				r.last_read = r.shift_byte;
		end else begin
			r.phase        = PH_BIT_LOW;
			r.slot_counter = low_len(r.operation, r.shift_byte[0], c);
		end
		return r;
	endfunction

	owm_state_t       n;
	logic             fin;
	logic             rej;
	logic [CNT_W-1:0] cnt_dec;

	always_comb begin
		n       = cur;
		fin     = 1'b0;
		rej     = 1'b0;
		cnt_dec = (cur.slot_counter != '0) ? cur.slot_counter - 10'd1 : '0;
		if (item.action != ACT_TICK) begin
			if (cur.phase != PH_IDLE) begin
				rej = 1'b1;
			end else if (item.action == ACT_RESET) begin
				n.operation    = OP_RESET;
				n.phase        = PH_RST_LOW;
				n.slot_counter = seg_len(cfg.reset_low);
			end else begin
				n.operation    = (item.action == ACT_WRITE) ? OP_WRITE : OP_READ;
				n.shift_byte   = (item.action == ACT_WRITE) ? item.write_data : 8'h00;
				n.bit_index    = 3'd0;
				n.phase        = PH_BIT_LOW;
				n.slot_counter = low_len(n.operation, n.shift_byte[0], cfg);
			end
		end else if (cur.phase != PH_IDLE) begin
			n.slot_counter = cnt_dec;
			if (cnt_dec == '0) begin
				unique case (cur.phase)
					PH_RST_LOW: begin
						n.phase        = PH_RST_WAIT;
						n.slot_counter = seg_len(cfg.presence_wait);
					end
					PH_RST_WAIT: begin
						n.presence_flag = !item.line_level;
						n.phase         = PH_RST_TAIL;
						n.slot_counter  = seg_len(cfg.reset_tail);
					end
					PH_RST_TAIL: begin
						n.phase = PH_IDLE;
						fin     = 1'b1;
					end
					PH_BIT_LOW: begin
						n.phase        = PH_BIT_WAIT;
						n.slot_counter = release_len(cur.operation, cur.shift_byte[0], cfg);
					end
					PH_BIT_WAIT: begin
						if (cur.operation == OP_READ) begin
							n.shift_byte   = {item.line_level, cur.shift_byte[7:1]};
							n.phase        = PH_BIT_TAIL;
							n.slot_counter = READ_TAIL_TICKS;
						end else begin
							n   = end_bit(n, cfg);
							fin = (cur.bit_index == 3'd7);
						end
					end
					PH_BIT_TAIL: begin
						n   = end_bit(n, cfg);
						fin = (cur.bit_index == 3'd7);
					end
					default: n.phase = PH_IDLE;
				endcase
			end
		end
	end

	assign nxt           = n;
	assign res.drive_low = (n.phase == PH_RST_LOW) || (n.phase == PH_BIT_LOW);
	assign res.busy      = (n.phase != PH_IDLE);
	assign res.done      = fin;
	assign res.presence  = n.presence_flag;
	assign res.read_data = n.last_read;
	assign res.rejected  = rej;

endmodule

// File: rtl/core/one_wire_bus_master_core.sv
// Single-wire bus master timing engine.
// Input channel (in_valid/in_ready): one request per item, action selects a
// tick (one microsecond, carrying the sampled line_level), a bus reset, a
// byte write (write_data, LSB first) or a byte read.
// Output channel (out_valid/out_ready): exactly one result per request, with
// the line drive, busy, done, presence, last read byte and rejected flag.
// Config channel (cfg_valid/cfg_ready): writes one of the eight 10-bit
// segment lengths; always ready. The user must write only while the engine
// is idle; the block itself does not enforce it. An accepted request is
// captured in the input register, then its result in the result register.
// Throughput: one request per cycle unless the output stalls; the step of
// the state machine and slot counter is combinational between the registers.
// Stall: while out_ready is low the result is held, one more request is
// captured in the input register, then in_ready drops.
// Reset: lengths return to their defaults, the engine goes idle and the
// presence flag and read byte clear; both registers empty.
module one_wire_bus_master_core
	import owm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [7:0]       write_data,
	input  logic             line_level,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             drive_low,
	output logic             busy_res,
	output logic             done_res,
	output logic             presence,
	output logic [7:0]       read_data,
	output logic             rejected,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	`include "one_wire_bus_master_core_assert.svh"

	owm_cfg_t   cfg;
	owm_state_t st_q;
	owm_state_t st_nxt;
	owm_res_t   res_nxt;
	owm_res_t   res_s2;
	owm_item_t  item_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       adv;

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_step u_step (
		.cfg  (cfg),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action     <= action;
			item_s1.write_data <= write_data;
			item_s1.line_level <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_IDLE;
			st_q.slot_counter  <= '0;
			st_q.bit_index     <= '0;
			st_q.shift_byte    <= '0;
			st_q.operation     <= OP_NONE;
			st_q.presence_flag <= 1'b0;
			st_q.last_read     <= '0;
			valid_s2           <= 1'b0;
		end else begin
			if (adv)
				st_q <= st_nxt;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign out_valid = valid_s2;
	assign drive_low = res_s2.drive_low;
	assign busy_res  = res_s2.busy;
	assign done_res  = res_s2.done;
	assign presence  = res_s2.presence;
	assign read_data = res_s2.read_data;
	assign rejected  = res_s2.rejected;

	`OWM_ASSERT(a_stall_blocks_input, (valid_s1 && valid_s2 && !out_ready) |-> !in_ready, "input taken while both stages are stalled")
	`OWM_ASSERT(a_step_gives_result, adv |=> valid_s2, "a stepped request left no result")
	`OWM_ASSERT(a_drive_needs_busy, (valid_s2 && drive_low) |-> busy_res, "line driven while idle")
	`OWM_ASSERT(a_done_not_busy, (valid_s2 && done_res) |-> (!busy_res && !rejected), "done with busy or rejected")
	`OWM_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!valid_s1 && !valid_s2), "stages not empty in reset")

endmodule
